// ===== design/fpr_pkg.sv =====
// Shared types, register indexes and helpers for the fixed pattern replace block.
// No dependencies; used by fpr_core and fixed_pattern_replace.
`default_nettype none

package fpr_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_PATTERN_LOW  = 3'd0;
	localparam cfg_idx_t CFG_PATTERN_HIGH = 3'd1;
	localparam cfg_idx_t CFG_REPLACE_LOW  = 3'd2;
	localparam cfg_idx_t CFG_REPLACE_HIGH = 3'd3;

	localparam int CFG_DATA_W = 64;
	localparam int TOTAL_W    = 32;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// Input beat
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_beat_t;

	// Output beat
	typedef struct packed {
		logic [7:0]         out_byte;
		logic               out_last;
		logic [TOTAL_W-1:0] match_total;
	} out_beat_t;

	// Byte i of a low/high register pair; bytes twelve and above read as zero
	function automatic logic [7:0] pick_byte(input logic [63:0] lo, input logic [31:0] hi,
		input int i);
		logic [7:0] b;
		b = 8'h00;
		if (i < 8) begin
			b = lo[8*i +: 8];
		end else if (i < 12) begin
			b = hi[8*(i-8) +: 8];
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== design/fpr_core.sv =====
// Window, match/replace logic, counter and configuration registers.
// Depends on fpr_pkg. Produces the full set of result beats for one accepted byte.
`default_nettype none

module fpr_core #(
	parameter int PATTERN_BYTES = 12
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          cfg_we,
	input  wire fpr_pkg::cfg_idx_t                       cfg_index,
	input  wire [fpr_pkg::CFG_DATA_W-1:0]                cfg_data,
	input  wire                                          fire,
	input  wire fpr_pkg::in_beat_t                       in_beat,
	output fpr_pkg::out_beat_t [PATTERN_BYTES-1:0]       results,
	output logic [$clog2(PATTERN_BYTES+1)-1:0]           res_n
);

	localparam int N  = PATTERN_BYTES;
	localparam int FW = $clog2(N+1);

	logic [63:0] pattern_low_q;
	logic [31:0] pattern_high_q;
	logic [63:0] replace_low_q;
	logic [31:0] replace_high_q;

	logic [7:0]                  win_q [N];
	logic [FW-1:0]               fill_q;
	logic [fpr_pkg::TOTAL_W-1:0] count_q;

	logic [7:0]                  w_ins [N];
	logic [7:0]                  w_new [N];
	logic [7:0]                  win_d [N];
	logic [FW-1:0]               fill_new;
	logic                        full;
	logic                        same;
	logic                        hit;
	logic [fpr_pkg::TOTAL_W-1:0] count_new;

	// Configuration writes; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			replace_low_q  <= '0;
			replace_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fpr_pkg::CFG_PATTERN_LOW:  pattern_low_q  <= cfg_data;
				fpr_pkg::CFG_PATTERN_HIGH: pattern_high_q <= cfg_data[31:0];
				fpr_pkg::CFG_REPLACE_LOW:  replace_low_q  <= cfg_data;
				fpr_pkg::CFG_REPLACE_HIGH: replace_high_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Insert the byte, compare a full window and overwrite on a hit
	always_comb begin
		full = (fill_q == FW'(N-1));
		same = 1'b1;
		for (int i = 0; i < N; i++) begin
			w_ins[i] = (fill_q == FW'(i)) ? in_beat.in_byte : win_q[i];
			if (w_ins[i] != fpr_pkg::pick_byte(pattern_low_q, pattern_high_q, i)) begin
				same = 1'b0;
			end
		end
		hit = full && same;
		for (int i = 0; i < N; i++) begin
			w_new[i] = hit ? fpr_pkg::pick_byte(replace_low_q, replace_high_q, i) : w_ins[i];
		end
		fill_new  = fill_q + FW'(1);
		count_new = (hit && count_q != fpr_pkg::TOTAL_MAX) ? count_q + 1'b1 : count_q;
	end

	// Result beats: window bytes in order, last flag and total on the final one
	always_comb begin
		for (int i = 0; i < N; i++) begin
			results[i].out_byte    = w_new[i];
			results[i].out_last    = in_beat.in_last && (fill_q == FW'(i));
			results[i].match_total = (in_beat.in_last && (fill_q == FW'(i))) ? count_new : '0;
		end
		if (in_beat.in_last) begin
			res_n = fill_new;
		end else if (full) begin
			res_n = FW'(1);
		end else begin
			res_n = '0;
		end
	end

	// Next window: shift out the oldest byte once full
	always_comb begin
		for (int i = 0; i < N-1; i++) begin
			win_d[i] = full ? w_new[i+1] : w_new[i];
		end
		win_d[N-1] = full ? 8'h00 : w_new[N-1];
	end

	// Window contents are payload; only the fill level and counter need reset
	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < N; i++) begin
				win_q[i] <= win_d[i];
			end
		end
	end

	// Advance fill level and counter; drop both at end of stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
		end else if (fire) begin
			if (in_beat.in_last) begin
				fill_q  <= '0;
				count_q <= '0;
			end else begin
				fill_q  <= full ? FW'(N-1) : fill_new;
				count_q <= count_new;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/fixed_pattern_replace.sv =====
// Fixed pattern search-and-replace over a byte stream: top level with output buffer.
// Depends on fpr_pkg and fpr_core.
//
// The block takes one byte a clock and rewrites it through a window of PATTERN_BYTES bytes:
// each full window that equals the search pattern is overwritten with the replacement before
// its oldest byte leaves. A byte comes out once PATTERN_BYTES-1 later bytes have entered, or
// at end of stream, when the whole window is flushed and the final beat carries the
// saturating replacement count. All the work for a byte is done in the cycle it is accepted;
// results wait in an output buffer of PATTERN_BYTES+1 beats that drains one beat a cycle
// while out_stall is low. Input is taken whenever at most one beat waits there, so the
// mid-stream rate is one byte per clock while out_stall is low; after a stream end, input
// stalls while the flushed window drains. Config is taken every cycle (cfg_ready tied high).
`default_nettype none

module fixed_pattern_replace #(
	parameter int PATTERN_BYTES = 12
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire fpr_pkg::cfg_idx_t         cfg_index,
	input  wire [fpr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire fpr_pkg::in_beat_t         in_data,
	output logic                           out_valid,
	input  wire                            out_stall,
	output fpr_pkg::out_beat_t             out_data
);

	localparam int N  = PATTERN_BYTES;
	localparam int D  = N + 1;
	localparam int FW = $clog2(N+1);
	localparam int CW = $clog2(D+1);

	fpr_pkg::out_beat_t [N-1:0] results;
	logic [FW-1:0]              res_n;
	logic                       fire;
	logic                       pop;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              cnt_after;
	fpr_pkg::out_beat_t         buf_q [D];
	fpr_pkg::out_beat_t         buf_d [D];

	assign cfg_ready = 1'b1;

	// Hold input while more than one beat waits
	assign in_stall  = (cnt_q > CW'(1));
	assign fire      = in_valid && !in_stall;
	assign out_valid = (cnt_q != '0);
	assign out_data  = buf_q[0];
	assign pop       = out_valid && !out_stall;
	assign cnt_after = cnt_q - CW'(pop);

	fpr_core #(
		.PATTERN_BYTES(PATTERN_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.in_beat   (in_data),
		.results   (results),
		.res_n     (res_n)
	);

	// Each buffer entry: shift down on a pop, then append new beats after what remains
	for (genvar j = 0; j < D; j++) begin : g_buf
		always_comb begin
			if (pop && j < D-1) begin
				buf_d[j] = buf_q[(j < D-1) ? j+1 : j];
			end else begin
				buf_d[j] = buf_q[j];
			end
			if (fire) begin
				if (cnt_after == '0) begin
					if (j < N && CW'(j) < CW'(res_n)) begin
						buf_d[j] = results[(j < N) ? j : 0];
					end
				end else begin
					if (j >= 1 && CW'(j) <= CW'(res_n)) begin
						buf_d[j] = results[(j >= 1) ? j-1 : 0];
					end
				end
			end
		end
	end

	// Buffer contents are payload
	always_ff @(posedge clk) begin
		for (int j = 0; j < D; j++) begin
			buf_q[j] <= buf_d[j];
		end
	end

	// Advance the occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_after + (fire ? CW'(res_n) : CW'(0));
		end
	end

	// Buffer never overfills
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(D))
		else $error("output buffer overfilled");

	// A byte that does not end the stream yields at most one beat
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && !in_data.in_last |-> res_n <= FW'(1))
		else $error("mid-stream byte produced several beats");

	// A byte that ends the stream always yields at least one beat
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_data.in_last |-> res_n != '0)
		else $error("end of stream produced no beat");

	// Taking the only waiting beat with nothing new leaves the output empty
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && cnt_q == CW'(1) && !fire |=> !out_valid)
		else $error("output valid after buffer drained");

endmodule

`default_nettype wire
